// ----- design/crlf_frame_deframer_defines.svh -----
// ----------------------------------------------------------------------------
// crlf_frame_deframer_defines.svh
// assertion macros shared by the deframer rtl
// ----------------------------------------------------------------------------
`ifndef CRLF_FRAME_DEFRAMER_DEFINES_SVH
`define CRLF_FRAME_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS

// checked property, switched off while reset is high
`define CFD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked property that also holds around reset
`define CFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CFD_ASSERT(lbl, clk, rst, prop, msg)
`define CFD_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- design/crlffd_pkg.sv -----
// ----------------------------------------------------------------------------
// crlffd_pkg
// types, constants and result codes for the cr lf frame deframer
// ----------------------------------------------------------------------------
`default_nettype none

package crlffd_pkg;

  // frame buffer capacity in bytes
  localparam int BUFFER_BYTES = 32;
  localparam int PTR_W        = $clog2(BUFFER_BYTES);

  // field widths of a result item
  localparam int DATA_W = 8;
  localparam int POS_W  = 5;

  // delimiter characters
  localparam logic [DATA_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [DATA_W-1:0] CHAR_LF = 8'h0A;

  // result codes
  localparam logic [1:0] EV_BYTE  = 2'd0;
  localparam logic [1:0] EV_DONE  = 2'd1;
  localparam logic [1:0] EV_ABORT = 2'd2;

  // one result item
  typedef struct packed {
    logic [1:0]        ev;
    logic [DATA_W-1:0] data;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  len;
    logic              last;
  } res_t;

  // results caused by one input item
  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } parse_out_t;

endpackage

`default_nettype wire

// ----- design/crlffd_parse.sv -----
// ----------------------------------------------------------------------------
// crlffd_parse
// framing state and per-byte result decode of the cr lf deframer
// ----------------------------------------------------------------------------
`default_nettype none

`include "crlf_frame_deframer_defines.svh"

module crlffd_parse (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [crlffd_pkg::DATA_W-1:0] rx_byte,
  input  wire logic                          advance,
  output crlffd_pkg::parse_out_t             res
);

  typedef enum logic [1:0] {
    HUNT_CR = 2'd0,
    HUNT_LF = 2'd1,
    BODY    = 2'd2,
    BODY_CR = 2'd3
  } phase_t;

  localparam logic [crlffd_pkg::PTR_W-1:0] LIM_ONE =
    crlffd_pkg::PTR_W'(crlffd_pkg::BUFFER_BYTES - 1);
  localparam logic [crlffd_pkg::PTR_W-1:0] LIM_TWO =
    crlffd_pkg::PTR_W'(crlffd_pkg::BUFFER_BYTES - 2);

  phase_t                         phase;
  phase_t                         phase_next;
  logic [crlffd_pkg::PTR_W-1:0]   wr_pos;
  logic [crlffd_pkg::PTR_W-1:0]   wr_pos_next;
  logic [crlffd_pkg::PTR_W-1:0]   wr_pos_inc;
  logic                           is_cr;
  logic                           is_lf;

  assign is_cr      = (rx_byte == crlffd_pkg::CHAR_CR);
  assign is_lf      = (rx_byte == crlffd_pkg::CHAR_LF);
  assign wr_pos_inc = wr_pos + crlffd_pkg::PTR_W'(1);

  // decode of the results and next state for the current byte
  always_comb begin
    phase_next  = phase;
    wr_pos_next = wr_pos;
    res         = '0;
    case (phase)
      HUNT_CR: begin
        if (is_cr) begin
          phase_next = HUNT_LF;
        end
      end
      HUNT_LF: begin
        if (is_lf) begin
          phase_next  = BODY;
          wr_pos_next = '0;
        end else begin
          phase_next = HUNT_CR;
        end
      end
      BODY: begin
        if (is_cr) begin
          phase_next = BODY_CR;
        end else if (wr_pos < LIM_ONE) begin
          res.count   = 2'd1;
          res.r0.ev   = crlffd_pkg::EV_BYTE;
          res.r0.data = rx_byte;
          res.r0.pos  = crlffd_pkg::POS_W'(wr_pos);
          res.r0.last = 1'b1;
          wr_pos_next = wr_pos_inc;
        end else begin
          res.count   = 2'd1;
          res.r0.ev   = crlffd_pkg::EV_ABORT;
          res.r0.last = 1'b1;
          phase_next  = HUNT_CR;
        end
      end
      BODY_CR: begin
        if (is_lf) begin
          res.count   = 2'd1;
          res.r0.ev   = crlffd_pkg::EV_DONE;
          res.r0.len  = crlffd_pkg::POS_W'(wr_pos);
          res.r0.last = 1'b1;
          phase_next  = HUNT_CR;
        end else if (wr_pos < LIM_TWO) begin
          // stray cr inside the body goes out ahead of this byte
          res.count   = 2'd2;
          res.r0.ev   = crlffd_pkg::EV_BYTE;
          res.r0.data = crlffd_pkg::CHAR_CR;
          res.r0.pos  = crlffd_pkg::POS_W'(wr_pos);
          res.r1.ev   = crlffd_pkg::EV_BYTE;
          res.r1.data = rx_byte;
          res.r1.pos  = crlffd_pkg::POS_W'(wr_pos_inc);
          res.r1.last = 1'b1;
          wr_pos_next = wr_pos + crlffd_pkg::PTR_W'(2);
          phase_next  = BODY;
        end else begin
          res.count   = 2'd1;
          res.r0.ev   = crlffd_pkg::EV_ABORT;
          res.r0.last = 1'b1;
          phase_next  = HUNT_CR;
        end
      end
      default: begin
        phase_next = HUNT_CR;
      end
    endcase
  end

  // framing state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= HUNT_CR;
      wr_pos <= '0;
    end else if (advance) begin
      phase  <= phase_next;
      wr_pos <= wr_pos_next;
    end
  end

  // write position never passes the last buffer slot
  `CFD_ASSERT(a_pos_in_range, clk, rst, wr_pos <= LIM_ONE, "write position beyond capacity")
  // a frame can only complete from the cr-seen phase
  `CFD_ASSERT(a_done_after_cr, clk, rst,
    (res.count != 2'd0 && res.r0.ev == crlffd_pkg::EV_DONE) |-> phase == BODY_CR,
    "frame complete outside cr-seen phase")
  // nothing comes out while hunting
  `CFD_ASSERT(a_quiet_hunt, clk, rst,
    (phase == HUNT_CR || phase == HUNT_LF) |-> res.count == 2'd0,
    "result produced while hunting")

endmodule

`default_nettype wire

// ----- design/crlf_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// crlf_frame_deframer
// extracts cr lf delimited frames from a received byte stream
// ----------------------------------------------------------------------------
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   rx_byte
//   out      output     out_valid / out_stall event_res, data_byte, position,
//                                             frame_length, last
//
// one byte is taken per cycle unless in_stall is high; a byte enters an input
// register, is decoded from there and its results land in a two-entry result
// queue. a stray cr inside a frame gives two results for the byte after it,
// but the cr itself gives none, so with the output free the queue keeps pace.
// a byte's results pass through the input register and the queue; the first
// waits longer once a pair has left a result waiting behind the head.
// rst is synchronous and clears the framing state, input register and queue.
// a stalled output keeps its item; the input stalls only when the queue lacks
// room for the results of the byte held in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "crlf_frame_deframer_defines.svh"

module crlf_frame_deframer (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [crlffd_pkg::DATA_W-1:0]     rx_byte,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [1:0]                             event_res,
  output logic [crlffd_pkg::DATA_W-1:0]          data_byte,
  output logic [crlffd_pkg::POS_W-1:0]           position,
  output logic [crlffd_pkg::POS_W-1:0]           frame_length,
  output logic                                   last
);

  logic                            in_vld;
  logic [crlffd_pkg::DATA_W-1:0]   in_byte;
  crlffd_pkg::parse_out_t          dec;
  crlffd_pkg::res_t                q0;
  crlffd_pkg::res_t                q1;
  crlffd_pkg::res_t                base0;
  logic [1:0]                      cnt;
  logic [1:0]                      cnt_next;
  logic [1:0]                      cnt_pop;
  logic [2:0]                      fill;
  logic                            pop;
  logic                            go;
  logic                            take;

  // byte decode and framing state
  crlffd_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .rx_byte (in_byte),
    .advance (go),
    .res     (dec)
  );

  // queue room check
  assign pop     = (cnt != 2'd0) && !out_stall;
  assign cnt_pop = cnt - {1'b0, pop};
  assign fill    = {1'b0, cnt_pop} + {1'b0, dec.count};
  assign go      = in_vld && (fill <= 3'd2);
  assign base0   = pop ? q1 : q0;

  assign in_stall = in_vld && !go;
  assign take     = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (take) begin
      in_vld <= 1'b1;
    end else if (go) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_byte <= rx_byte;
    end
  end

  // result queue count
  always_comb begin
    cnt_next = cnt_pop;
    if (go) begin
      cnt_next = fill[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // result queue entries: shift on pop, append decoded results behind
  always_ff @(posedge clk) begin
    if (go && cnt_pop == 2'd0) begin
      q0 <= dec.r0;
      q1 <= dec.r1;
    end else begin
      q0 <= base0;
      if (go && cnt_pop == 2'd1) begin
        q1 <= dec.r0;
      end
    end
  end

  // output port
  assign out_valid    = (cnt != 2'd0);
  assign event_res    = q0.ev;
  assign data_byte    = q0.data;
  assign position     = q0.pos;
  assign frame_length = q0.len;
  assign last         = q0.last;

  // queue never holds more than two results
  `CFD_ASSERT_ALWAYS(a_cnt_max, clk, rst || cnt <= 2'd2, "result queue overfilled")
  // a head result that is not last has its partner behind it
  `CFD_ASSERT(a_pair_kept, clk, rst, (out_valid && !last) |-> cnt == 2'd2,
    "first of a pair without its partner")
  // a held output never loses queue entries
  `CFD_ASSERT(a_hold_count, clk, rst, (out_valid && out_stall) |=> cnt >= $past(cnt),
    "queue shrank while output stalled")

endmodule

`default_nettype wire
